>>> rtl/rbst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rbst_pkg;

	// default geometry
	localparam int unsigned COORD_WIDTH_DEF = 32;
	localparam int unsigned FRAC_BITS_DEF   = 16;

	// epsilon register
	localparam int unsigned EPS_WIDTH = 16;
	localparam logic [EPS_WIDTH-1:0] EPS_RESET = 16'd7;

	// number of axes; each axis has an entry and an exit lane
	localparam int unsigned NUM_AXES = 3;

	// per-item side information carried next to the divider lanes
	typedef struct packed {
		logic [NUM_AXES-1:0] axis_zero;  // direction component is zero
		logic                miss;       // zero direction with origin outside its slab
	} meta_t;

endpackage
`default_nettype wire

>>> rtl/rbst_div_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module rbst_div_lane #(
	parameter int unsigned W = rbst_pkg::COORD_WIDTH_DEF,
	parameter int unsigned F = rbst_pkg::FRAC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic signed [W-1:0] a,
	input  wire logic signed [W-1:0] b,
	input  wire logic signed [W-1:0] d,
	output logic signed [W-1:0]      quot
);

	// dividend is |a - b| * 2^F
	localparam int unsigned N  = W + 1 + F;
	localparam int unsigned HW = N - W;

	logic signed [W:0] diff;
	logic [W:0]        mag;
	logic [W-1:0]      dmag;
	logic [N-1:0]      dvd;
	logic [HW-1:0]     dvd_hi;
	logic              neg_c;
	logic              ovf_c;

	// front end: magnitudes, sign and overflow of the quotient
	always_comb begin
		diff   = (W+1)'(a) - (W+1)'(b);
		mag    = diff[W] ? (W+1)'(-diff) : diff;
		dmag   = d[W-1] ? W'(-d) : W'(d);
		dvd    = {mag, {F{1'b0}}};
		dvd_hi = dvd[N-1:W];
		neg_c  = (mag != '0) && ((a < b) != d[W-1]);
		// quotient reaches 2^W exactly when the upper dividend part is not below the divisor
		ovf_c  = (N'(dvd_hi) >= N'(dmag));
	end

	logic [W-1:0] rem_s [0:W];
	logic [W-1:0] quo_s [0:W];
	logic [W-1:0] low_s [0:W];
	logic [W-1:0] dm_s  [0:W];
	logic         neg_s [0:W];
	logic         ovf_s [0:W];

	// first stage register
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= W'(dvd_hi);
			quo_s[0] <= '0;
			low_s[0] <= dvd[W-1:0];
			dm_s[0]  <= dmag;
			neg_s[0] <= neg_c;
			ovf_s[0] <= ovf_c;
		end
	end

	// one quotient bit per stage, restoring division
	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [W:0] trial;
		logic       ge;
		always_comb begin
			trial = {rem_s[k], low_s[k][W-1-k]};
			ge    = (trial >= {1'b0, dm_s[k]});
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? W'(trial - {1'b0, dm_s[k]}) : W'(trial);
				quo_s[k+1] <= {quo_s[k][W-2:0], ge};
				low_s[k+1] <= low_s[k];
				dm_s[k+1]  <= dm_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	// saturation and sign
	logic [W-1:0] lim;
	logic [W-1:0] qsat;
	always_comb begin
		lim  = neg_s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		qsat = (ovf_s[W] || (quo_s[W] > lim)) ? lim : quo_s[W];
	end

	logic signed [W-1:0] dist_q;
	always_ff @(posedge clk) begin
		if (en) begin
			dist_q <= neg_s[W] ? $signed(W'(-qsat)) : $signed(qsat);
		end
	end

	assign quot = dist_q;

endmodule
`default_nettype wire

>>> rtl/rbst_merge.sv
`timescale 1ns / 1ps
`default_nettype none
module rbst_merge #(
	parameter int unsigned W = rbst_pkg::COORD_WIDTH_DEF
) (
	input  wire logic [rbst_pkg::NUM_AXES-1:0][W-1:0] en_dist,
	input  wire logic [rbst_pkg::NUM_AXES-1:0][W-1:0] ex_dist,
	input  wire rbst_pkg::meta_t                      meta,
	input  wire logic [rbst_pkg::EPS_WIDTH-1:0]       eps,
	output logic                                      hit
);

	logic signed [W-1:0] entry;
	logic signed [W-1:0] exitv;
	logic signed [W-1:0] tmin;
	logic signed [W-1:0] tmax;

	// entry is the largest, exit the smallest; zero-direction axes span everything
	always_comb begin
		tmin  = {1'b1, {(W-1){1'b0}}};
		tmax  = {1'b0, {(W-1){1'b1}}};
		entry = tmin;
		exitv = tmax;
		for (int i = 0; i < rbst_pkg::NUM_AXES; i++) begin
			if (!meta.axis_zero[i]) begin
				if ($signed(en_dist[i]) > entry) entry = $signed(en_dist[i]);
				if ($signed(ex_dist[i]) < exitv) exitv = $signed(ex_dist[i]);
			end
		end
		hit = !meta.miss && (entry < exitv) && (exitv > $signed({1'b0, eps}));
	end

endmodule
`default_nettype wire

>>> rtl/ray_box_slab_test_core.sv
// Ray against axis-aligned box hit test, signed fixed point (Q16.16 by default).
// Input channel in_valid/in_ready carries one ray and one box per beat; output
// channel out_valid/out_ready returns hit_flag, one beat per input beat, in order.
// Configuration channel cfg_valid/cfg_ready writes epsilon (exit must exceed it);
// cfg_ready is always high. Write it only while no beat is in flight.
// Six divider lanes (entry and exit plane for each axis) run side by side, each a
// restoring divider with one quotient bit per stage, followed by a merge stage.
// A beat passes the lane input register, the COORD_WIDTH quotient stages and the
// lane output register, then the merge into the output register.
// Throughput: one beat per cycle while the receiver does not stall the output.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready drops; with the output register empty the pipeline keeps moving.
// Reset clears all valid flags and sets epsilon to 7; results in flight are lost.
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_test_core #(
	parameter int unsigned COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF,
	parameter int unsigned FRAC_BITS   = rbst_pkg::FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [rbst_pkg::EPS_WIDTH-1:0]    cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [COORD_WIDTH-1:0]     origin_x,
	input  wire logic signed [COORD_WIDTH-1:0]     origin_y,
	input  wire logic signed [COORD_WIDTH-1:0]     origin_z,
	input  wire logic signed [COORD_WIDTH-1:0]     dir_x,
	input  wire logic signed [COORD_WIDTH-1:0]     dir_y,
	input  wire logic signed [COORD_WIDTH-1:0]     dir_z,
	input  wire logic signed [COORD_WIDTH-1:0]     box_min_x,
	input  wire logic signed [COORD_WIDTH-1:0]     box_min_y,
	input  wire logic signed [COORD_WIDTH-1:0]     box_min_z,
	input  wire logic signed [COORD_WIDTH-1:0]     box_max_x,
	input  wire logic signed [COORD_WIDTH-1:0]     box_max_y,
	input  wire logic signed [COORD_WIDTH-1:0]     box_max_z,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   hit_flag
);

	localparam int unsigned W   = COORD_WIDTH;
	localparam int unsigned NA  = rbst_pkg::NUM_AXES;
	localparam int unsigned LAT = W + 2;

	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// epsilon register
	logic [rbst_pkg::EPS_WIDTH-1:0] epsilon_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epsilon_q <= rbst_pkg::EPS_RESET;
		end else if (cfg_valid) begin
			epsilon_q <= cfg_data;
		end
	end

	// per-axis views of the input beat
	logic [NA-1:0][W-1:0] o_v, d_v, lo_v, hi_v;
	assign o_v  = {origin_z, origin_y, origin_x};
	assign d_v  = {dir_z, dir_y, dir_x};
	assign lo_v = {box_min_z, box_min_y, box_min_x};
	assign hi_v = {box_max_z, box_max_y, box_max_x};

	rbst_pkg::meta_t      meta_c;
	logic [NA-1:0][W-1:0] en_dist, ex_dist;

	// zero-direction handling
	always_comb begin
		meta_c = '0;
		for (int i = 0; i < NA; i++) begin
			meta_c.axis_zero[i] = (d_v[i] == '0);
			if ((d_v[i] == '0) &&
			    !(($signed(lo_v[i]) <= $signed(o_v[i])) && ($signed(o_v[i]) <= $signed(hi_v[i]))))
				meta_c.miss = 1'b1;
		end
	end

	// divider lanes, planes swapped for a negative direction
	for (genvar i = 0; i < NA; i++) begin : g_axis
		logic signed [W-1:0] near_p, far_p;
		assign near_p = d_v[i][W-1] ? $signed(hi_v[i]) : $signed(lo_v[i]);
		assign far_p  = d_v[i][W-1] ? $signed(lo_v[i]) : $signed(hi_v[i]);

		rbst_div_lane #(.W(W), .F(FRAC_BITS)) u_en (
			.clk  (clk),
			.en   (adv),
			.a    (near_p),
			.b    ($signed(o_v[i])),
			.d    ($signed(d_v[i])),
			.quot (en_dist[i])
		);

		rbst_div_lane #(.W(W), .F(FRAC_BITS)) u_ex (
			.clk  (clk),
			.en   (adv),
			.a    (far_p),
			.b    ($signed(o_v[i])),
			.d    ($signed(d_v[i])),
			.quot (ex_dist[i])
		);
	end

	// valid flags and side information alongside the lanes
	logic            vld_s  [0:LAT-1];
	rbst_pkg::meta_t meta_s [0:LAT-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) vld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < LAT; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s[0] <= meta_c;
			for (int k = 1; k < LAT; k++) meta_s[k] <= meta_s[k-1];
		end
	end

	// merge of the lane results
	logic hit_c;
	rbst_merge #(.W(W)) u_merge (
		.en_dist (en_dist),
		.ex_dist (ex_dist),
		.meta    (meta_s[LAT-1]),
		.eps     (epsilon_q),
		.hit     (hit_c)
	);

	// output register
	logic hit_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_s[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q <= hit_c;
		end
	end

	assign hit_flag = hit_q;

endmodule
`default_nettype wire
